FILE: design/hcb_pkg.sv
// Shared types and constants for the Huffman code builder.
package hcb_pkg;

  localparam int DEF_MAX_SYMBOLS = 16;
  localparam int DEF_WEIGHT_BITS = 16;

  localparam int SYM_W       = 8;
  localparam int IN_WEIGHT_W = 16;
  localparam int LEN_W       = 4;
  localparam int CODE_W      = 15;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_MERGE,
    OP_CLEAR
  } cell_op_e;

  typedef enum logic [2:0] {
    S_LOAD,
    S_MERGE,
    S_RD,
    S_EX,
    S_POP,
    S_CLR
  } state_e;

endpackage

FILE: design/huffman_code_builder.sv
// Huffman code builder: sorted cell chain, tree store and depth-first code walk.
// Load: one item per cycle; the first MAX_SYMBOLS go into the sorted cell chain on arrival.
// After the last item, n-1 merges (one chain shift-and-insert each), then the walk, which
// reads then examines each tree node, a leaf waiting for a free output, and pops saved branches.
// Reset clears control state and the chain valid bits; tree and stack memories need no clear.
// Only one set is in work at a time; no input from the last item until the last code's clear.
module huffman_code_builder
  import hcb_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [7:0] symbol, [23:8] weight
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   s_axis_tlast_i,   // last_symbol
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [7:0] out_symbol, [11:8] code_length, [26:12] code_bits, [31:27] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o    // last_code
);

  // Only the low weight bits that the input field carries take part.
  localparam int WB  = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
  localparam int AW  = $clog2(MAX_SYMBOLS);
  localparam int NW  = WB + AW;                     // exact sum of all weights
  localparam int IDW = $clog2(2 * MAX_SYMBOLS);     // leaf or node id
  localparam int CW  = $clog2(MAX_SYMBOLS + 1);     // symbol count
  localparam int DW  = (AW > LEN_W) ? AW : LEN_W;   // walk depth
  localparam int SW  = IDW + DW + CODE_W;           // stack entry

  state_e state_q, state_d;

  logic [CW-1:0]     cnt_q, cnt_d;    // live chain entries
  logic [CW-1:0]     n_q, n_d;        // leaves in this set
  logic [IDW-1:0]    node_q, node_d;  // next internal node id
  logic [IDW-1:0]    cur_q, cur_d;
  logic [DW-1:0]     depth_q, depth_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic [CW-1:0]     sp_q, sp_d;

  logic              ov_q, ov_d;
  logic [SYM_W-1:0]  osym_q, osym_d;
  logic [LEN_W-1:0]  olen_q, olen_d;
  logic [CODE_W-1:0] obits_q, obits_d;
  logic              olast_q, olast_d;

  // Tree and walk stores
  logic [SYM_W-1:0] leaf_mem  [MAX_SYMBOLS];
  logic [IDW-1:0]   zero_mem  [2*MAX_SYMBOLS];
  logic [IDW-1:0]   one_mem   [2*MAX_SYMBOLS];
  logic [SW-1:0]    stack_mem [MAX_SYMBOLS];

  logic [SYM_W-1:0] rd_sym_q;
  logic [IDW-1:0]   rd_zero_q, rd_one_q;
  logic [SW-1:0]    stk_rd_q;

  logic             leaf_we, tree_we, stk_we, stk_re;
  logic [AW-1:0]    stk_ra;
  logic [SW-1:0]    stk_wd;

  // Chain wiring
  cell_op_e         op;
  logic [NW-1:0]    key;
  logic [IDW-1:0]   new_id;
  logic             c_valid [MAX_SYMBOLS];
  logic [NW-1:0]    c_w     [MAX_SYMBOLS];
  logic [IDW-1:0]   c_id    [MAX_SYMBOLS];
  logic             c_lt    [MAX_SYMBOLS];

  logic             accept;
  logic             is_leaf;
  logic             out_free;
  logic [NW-1:0]    in_w;

  assign in_w     = NW'(s_axis_tdata_i[SYM_W +: WB]);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_leaf  = cur_q < IDW'(n_q);
  assign out_free = !ov_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == S_LOAD);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - SYM_W - LEN_W - CODE_W)'(0), obits_q, olen_q, osym_q};

  genvar k;
  generate
    for (k = 0; k < MAX_SYMBOLS; k++) begin : g_cell
      logic           p_valid, p_lt, a_valid, a_lt, b_valid, b_lt;
      logic [NW-1:0]  p_w, a_w, b_w;
      logic [IDW-1:0] p_id, a_id, b_id;

      if (k == 0) begin : g_head
        // in front of the chain everything counts as lighter
        assign p_valid = 1'b0;
        assign p_w     = '0;
        assign p_id    = '0;
        assign p_lt    = 1'b1;
      end else begin : g_prev
        assign p_valid = c_valid[k-1];
        assign p_w     = c_w[k-1];
        assign p_id    = c_id[k-1];
        assign p_lt    = c_lt[k-1];
      end

      if (k + 1 < MAX_SYMBOLS) begin : g_n1
        assign a_valid = c_valid[k+1];
        assign a_w     = c_w[k+1];
        assign a_id    = c_id[k+1];
        // cell 1 leaves in a merge, so the head takes the node when nothing is lighter
        assign a_lt    = (k == 0) ? 1'b1 : c_lt[k+1];
      end else begin : g_n1_end
        assign a_valid = 1'b0;
        assign a_w     = '0;
        assign a_id    = '0;
        assign a_lt    = 1'b0;
      end

      if (k + 2 < MAX_SYMBOLS) begin : g_n2
        assign b_valid = c_valid[k+2];
        assign b_w     = c_w[k+2];
        assign b_id    = c_id[k+2];
        assign b_lt    = c_lt[k+2];
      end else begin : g_n2_end
        assign b_valid = 1'b0;
        assign b_w     = '0;
        assign b_id    = '0;
        assign b_lt    = 1'b0;
      end

      hcb_cell #(
        .NW  (NW),
        .IDW (IDW)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .op_i         (op),
        .key_i        (key),
        .new_id_i     (new_id),
        .prev_valid_i (p_valid),
        .prev_w_i     (p_w),
        .prev_id_i    (p_id),
        .prev_lt_i    (p_lt),
        .n1_valid_i   (a_valid),
        .n1_w_i       (a_w),
        .n1_id_i      (a_id),
        .n1_lt_i      (a_lt),
        .n2_valid_i   (b_valid),
        .n2_w_i       (b_w),
        .n2_id_i      (b_id),
        .n2_lt_i      (b_lt),
        .valid_o      (c_valid[k]),
        .w_o          (c_w[k]),
        .id_o         (c_id[k]),
        .lt_o         (c_lt[k])
      );
    end
  endgenerate

  // Control: load, merge, walk and clear
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    node_d  = node_q;
    cur_d   = cur_q;
    depth_d = depth_q;
    code_d  = code_q;
    sp_d    = sp_q;
    ov_d    = ov_q && !m_axis_tready_i;
    osym_d  = osym_q;
    olen_d  = olen_q;
    obits_d = obits_q;
    olast_d = olast_q;
    op      = OP_HOLD;
    key     = in_w;
    new_id  = IDW'(cnt_q);
    leaf_we = 1'b0;
    tree_we = 1'b0;
    stk_we  = 1'b0;
    stk_re  = 1'b0;
    stk_ra  = AW'(sp_q - 1'b1);
    stk_wd  = {rd_one_q, DW'(depth_q + 1'b1), code_q[CODE_W-2:0], 1'b1};

    case (state_q)
      S_LOAD: begin
        if (accept) begin
          // hold nothing beyond the store size; a marked item still starts the build
          if (cnt_q < CW'(MAX_SYMBOLS)) begin
            leaf_we = 1'b1;
            op      = OP_LOAD;
            cnt_d   = cnt_q + 1'b1;
          end
          if (s_axis_tlast_i) begin
            n_d     = cnt_d;
            node_d  = IDW'(cnt_d);
            state_d = S_MERGE;
          end
        end
      end
      S_MERGE: begin
        if (cnt_q > CW'(1)) begin
          // lightest two sit in cells 0 and 1: combine and re-insert the node
          key     = c_w[0] + c_w[1];
          new_id  = node_q;
          op      = OP_MERGE;
          tree_we = 1'b1;
          node_d  = node_q + 1'b1;
          cnt_d   = cnt_q - 1'b1;
        end else begin
          cur_d   = c_id[0];
          depth_d = '0;
          code_d  = '0;
          sp_d    = '0;
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_EX;
      S_EX: begin
        if (is_leaf) begin
          if (out_free) begin
            ov_d    = 1'b1;
            osym_d  = rd_sym_q;
            olen_d  = depth_q[LEN_W-1:0];
            obits_d = code_q;
            olast_d = (sp_q == '0);
            if (sp_q == '0) begin
              state_d = S_CLR;
            end else begin
              stk_re  = 1'b1;
              sp_d    = sp_q - 1'b1;
              state_d = S_POP;
            end
          end
        end else begin
          // push branch one, descend into branch zero
          stk_we  = 1'b1;
          sp_d    = sp_q + 1'b1;
          cur_d   = rd_zero_q;
          depth_d = DW'(depth_q + 1'b1);
          code_d  = {code_q[CODE_W-2:0], 1'b0};
          state_d = S_RD;
        end
      end
      S_POP: begin
        cur_d   = stk_rd_q[SW-1 -: IDW];
        depth_d = stk_rd_q[CODE_W +: DW];
        code_d  = stk_rd_q[CODE_W-1:0];
        state_d = S_RD;
      end
      S_CLR: begin
        op      = OP_CLEAR;
        cnt_d   = '0;
        state_d = S_LOAD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      n_q     <= '0;
      node_q  <= '0;
      sp_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      node_q  <= node_d;
      sp_q    <= sp_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    depth_q <= depth_d;
    code_q  <= code_d;
    osym_q  <= osym_d;
    olen_q  <= olen_d;
    obits_q <= obits_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[cnt_q[AW-1:0]] <= s_axis_tdata_i[SYM_W-1:0];
    end
    if (state_q == S_RD) begin
      rd_sym_q <= leaf_mem[cur_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tree_we) begin
      zero_mem[node_q] <= c_id[1];
    end
    if (state_q == S_RD) begin
      rd_zero_q <= zero_mem[cur_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tree_we) begin
      one_mem[node_q] <= c_id[0];
    end
    if (state_q == S_RD) begin
      rd_one_q <= one_mem[cur_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[sp_q[AW-1:0]] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd_q <= stack_mem[stk_ra];
    end
  end

endmodule

FILE: design/hcb_cell.sv
// One cell of the sorted weight chain (lightest entry in cell 0).
module hcb_cell
  import hcb_pkg::*;
#(
  parameter int NW  = 20,
  parameter int IDW = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cell_op_e       op_i,
  input  logic [NW-1:0]  key_i,
  input  logic [IDW-1:0] new_id_i,
  input  logic           prev_valid_i,
  input  logic [NW-1:0]  prev_w_i,
  input  logic [IDW-1:0] prev_id_i,
  input  logic           prev_lt_i,
  input  logic           n1_valid_i,
  input  logic [NW-1:0]  n1_w_i,
  input  logic [IDW-1:0] n1_id_i,
  input  logic           n1_lt_i,
  input  logic           n2_valid_i,
  input  logic [NW-1:0]  n2_w_i,
  input  logic [IDW-1:0] n2_id_i,
  input  logic           n2_lt_i,
  output logic           valid_o,
  output logic [NW-1:0]  w_o,
  output logic [IDW-1:0] id_o,
  output logic           lt_o
);

  logic           valid_q, valid_d;
  logic [NW-1:0]  w_q, w_d;
  logic [IDW-1:0] id_q, id_d;

  // strictly lighter entries stay ahead of the key, so on a tie the key goes in front
  assign lt_o    = valid_q && (w_q < key_i);
  assign valid_o = valid_q;
  assign w_o     = w_q;
  assign id_o    = id_q;

  always_comb begin
    valid_d = valid_q;
    w_d     = w_q;
    id_d    = id_q;
    case (op_i)
      OP_LOAD: begin
        if (lt_o) begin
          valid_d = valid_q;
        end else if (prev_lt_i) begin
          valid_d = 1'b1;
          w_d     = key_i;
          id_d    = new_id_i;
        end else begin
          valid_d = prev_valid_i;
          w_d     = prev_w_i;
          id_d    = prev_id_i;
        end
      end
      OP_MERGE: begin
        if (n2_lt_i) begin
          valid_d = n2_valid_i;
          w_d     = n2_w_i;
          id_d    = n2_id_i;
        end else if (n1_lt_i) begin
          valid_d = 1'b1;
          w_d     = key_i;
          id_d    = new_id_i;
        end else begin
          valid_d = n1_valid_i;
          w_d     = n1_w_i;
          id_d    = n1_id_i;
        end
      end
      OP_CLEAR: valid_d = 1'b0;
      default:  valid_d = valid_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q  <= w_d;
    id_q <= id_d;
  end

endmodule

FILE: sim/hcb_checker.sv
// Stream monitor, code-table predictor and comparator for the Huffman code builder.
`timescale 1ns / 1ps
module hcb_checker
  import hcb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   s_axis_tlast_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                   m_axis_tlast_i,
  output int                     errors_o,
  output int                     pending_o,
  output int                     sets_o,
  output int                     codes_o
);
  localparam int NSYM = DEF_MAX_SYMBOLS;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] bits;
    logic              last;
  } code_t;

  code_t       code_q[$];
  int          held;
  logic [7:0]  leaf_sym[NSYM];
  logic [20:0] wt[2*NSYM];
  int          zero_kid[2*NSYM], one_kid[2*NSYM];
  int          order[NSYM];

  task automatic bubble_up(input int pos);
    int j, t;
    j = pos;
    while (j >= 1 && wt[order[j]] > wt[order[j-1]]) begin
      t = order[j]; order[j] = order[j-1]; order[j-1] = t;
      j--;
    end
  endtask

  // Build the tree for the held set and queue one code per leaf, walk order.
  task automatic build_codes();
    int n, nxt, top, nd, dep;
    int stk[$];
    int dq[$];
    logic [31:0] cq[$];
    logic [31:0] c;
    code_t e;
    n = held;
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = 1; i < n; i++) bubble_up(i);
    nxt = n;
    for (int i = n - 1; i >= 1; i--) begin
      one_kid[nxt]  = order[i];
      zero_kid[nxt] = order[i-1];
      wt[nxt]       = wt[order[i]] + wt[order[i-1]];
      order[i-1]    = nxt;
      nxt++;
      bubble_up(i - 1);
    end
    stk.push_back(order[0]); dq.push_back(0); cq.push_back(0);
    while (stk.size() > 0) begin
      nd = stk.pop_back(); dep = dq.pop_back(); c = cq.pop_back();
      if (nd < n) begin
        e.sym = leaf_sym[nd]; e.len = dep[LEN_W-1:0]; e.bits = c[CODE_W-1:0]; e.last = 1'b0;
        code_q.push_back(e);
      end else begin
        stk.push_back(one_kid[nd]);  dq.push_back(dep + 1); cq.push_back({c[30:0], 1'b1});
        stk.push_back(zero_kid[nd]); dq.push_back(dep + 1); cq.push_back({c[30:0], 1'b0});
      end
    end
    code_q[code_q.size()-1].last = 1'b1;
    held = 0;
    sets_o++;
  endtask

  task automatic report(input string what);
    errors_o++;
    $display("%0t MISMATCH: %s", $realtime, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    code_t got, want;
    if (!rst_ni) begin
      held = 0; errors_o = 0; sets_o = 0; codes_o = 0;
      code_q.delete();
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (held < NSYM) begin
          leaf_sym[held] = s_axis_tdata_i[7:0];
          wt[held]       = {5'd0, s_axis_tdata_i[23:8]};
          held++;
        end
        if (s_axis_tlast_i) build_codes();
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        codes_o++;
        got.sym  = m_axis_tdata_i[7:0];
        got.len  = m_axis_tdata_i[11:8];
        got.bits = m_axis_tdata_i[26:12];
        got.last = m_axis_tlast_i;
        if (code_q.size() == 0) begin
          report($sformatf("unexpected code sym=%0h", got.sym));
        end else begin
          want = code_q.pop_front();
          if (got.sym !== want.sym)
            report($sformatf("symbol %0h, want %0h", got.sym, want.sym));
          if (got.len !== want.len)
            report($sformatf("sym %0h length %0d, want %0d", want.sym, got.len, want.len));
          if (got.bits !== want.bits)
            report($sformatf("sym %0h code %0h, want %0h", want.sym, got.bits, want.bits));
          if (got.last !== want.last)
            report($sformatf("sym %0h last %0b, want %0b", want.sym, got.last, want.last));
          if (m_axis_tdata_i[31:27] !== 5'd0) report("padding bits not zero");
        end
      end
    end
    pending_o = code_q.size();
  end
endmodule

FILE: sim/tb.sv
// Testbench top: stimulus, handshake idling and verdict for the Huffman code builder.
`timescale 1ns / 1ps
module tb;
  import hcb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0, s_last = 1'b0, m_ready = 1'b0;
  logic hold_off = 1'b0;
  logic [IN_TDATA_W-1:0] s_data = '0;
  logic s_ready, m_valid, m_last;
  logic [OUT_TDATA_W-1:0] m_data;
  int errors, pending, sets, codes;
  int gap_pct = 0, stall_pct = 0, cycle = 0;

  localparam int CYCLE_LIMIT = 500000;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  huffman_code_builder uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data),   .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data),   .m_axis_tlast_o(m_last)
  );

  hcb_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready),
    .s_axis_tdata_i(s_data),   .s_axis_tlast_i(s_last),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_i(m_data),   .m_axis_tlast_i(m_last),
    .errors_o(errors), .pending_o(pending), .sets_o(sets), .codes_o(codes)
  );

  // Receiver: stall at random, or hold off completely while a hold-off is running.
  always @(posedge clk_i) begin
    if (hold_off) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run once the cycle count passes CYCLE_LIMIT.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one item, idling at random first, and hold it until the block takes it.
  task automatic offer(input logic [7:0] sym, input logic [15:0] w, input logic lst);
    while ($urandom_range(99) < gap_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {w, sym};
    s_last  <= lst;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task automatic drop_valid();
    s_valid <= 1'b0;
    s_last  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random set: mostly small, now and then overfilled past the symbol store.
  task automatic random_set();
    int n, wsel;
    n = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 8);
    wsel = $urandom_range(3);
    for (int i = 0; i < n; i++)
      offer(8'($urandom_range(255)),
            16'(wsel == 0 ? $urandom_range(3) : (wsel == 1 ? $urandom_range(40) : $urandom)),
            i == n - 1);
  endtask

  task automatic wait_drained();
    drop_valid();
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  initial begin
    int fa, fb, t, sent;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: lone symbol, extreme weights, ties, deepest possible tree.
    offer(8'hFF, 16'hFFFF, 1'b1);
    offer(8'h00, 16'h0000, 1'b0);
    offer(8'hA5, 16'hFFFF, 1'b1);
    offer(8'h11, 16'd7, 1'b0);
    offer(8'h22, 16'd7, 1'b0);
    offer(8'h33, 16'd7, 1'b1);
    fa = 1; fb = 1;
    for (int i = 0; i < 16; i++) begin
      offer(8'h40 + i[7:0], fa[15:0], i == 15);
      t = fa + fb; fa = fb; fb = t;
    end
    wait_drained();

    // Random phases: free running, sender idle, receiver stalling, both.
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = (ph == 1) ? 76 : (ph == 3 ? 29 : 0);
      stall_pct = (ph == 2) ? 76 : (ph == 3 ? 29 : 0);
      for (int k = 0; k < 3; k++) random_set();
      if (ph == 0) begin
        // Hold the receiver off for a counted stretch while two sets are offered.
        fork
          begin
            hold_off <= 1'b1;
            repeat (400) @(posedge clk_i);
            hold_off <= 1'b0;
          end
          begin
            random_set();
            random_set();
          end
        join
      end
      wait_drained();
    end

    $display("Covered %0d code sets and %0d codes, including a lone symbol, ties,", sets, codes);
    $display("a fifteen-bit deep tree, overfilled sets and long receiver hold-off.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
